>>> src/psd_pkg.sv
package psd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIST_BITS = 33;

  // Control bits that travel with each word through the pipeline
  typedef struct packed {
    logic valid;
    logic degen;
  } psd_ctl_t;

endpackage

>>> src/point_segment_distance_core.sv
// Point to segment distance, fully pipelined: one word accepted per cycle while
// ready_o is high, and each result passes through three front stages, the
// bit-per-stage divider (FRAC_BITS stages), four residual stages, the square root
// (COORD_BITS+FRAC_BITS+4 stages) and the output register. ready_o falls only
// when the output holds a result that is not taken; the whole pipeline then
// stalls together.
module point_segment_distance_core
  import psd_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [DIST_BITS-1:0]         distance_o,
  output logic                         degenerate_o
);

  localparam int DW = COORD_BITS + 1;           // differences
  localparam int PRW = 2 * DW;                  // products
  localparam int NW = PRW + 1;                  // dot / length
  localparam int RXW = DW + FRAC_BITS + 2;      // residual
  localparam int SQW = 2 * RXW + 2;             // sum of squares, even
  localparam int RTW = SQW / 2;

  logic en;
  assign en = !valid_o || ready_i;
  assign ready_o = en;

  // Stage 1: differences
  logic        v1_q;
  logic signed [DW-1:0] dx_q, dy_q, qx_q, qy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DW'(seg_end_x_i) - DW'(seg_start_x_i);
      dy_q <= DW'(seg_end_y_i) - DW'(seg_start_y_i);
      qx_q <= DW'(point_x_i) - DW'(seg_start_x_i);
      qy_q <= DW'(point_y_i) - DW'(seg_start_y_i);
    end
  end

  // Stage 2: four products
  logic v2_q, dg2_q;
  logic signed [PRW-1:0] pxx_q, pyy_q, dxx_q, dyy_q;
  logic signed [DW-1:0]  dx2_q, dy2_q, qx2_q, qy2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= PRW'(qx_q * dx_q);
      pyy_q <= PRW'(qy_q * dy_q);
      dxx_q <= PRW'(dx_q * dx_q);
      dyy_q <= PRW'(dy_q * dy_q);
      dg2_q <= (dx_q == '0) && (dy_q == '0);
      dx2_q <= dx_q; dy2_q <= dy_q; qx2_q <= qx_q; qy2_q <= qy_q;
    end
  end

  // Stage 3: dot product and squared length, clamp decision
  logic v3_q, dg3_q;
  logic signed [NW-1:0] num_q, den_q;
  logic signed [NW-1:0] num_d, den_d;
  logic signed [DW-1:0] dx3_q, dy3_q, qx3_q, qy3_q;
  assign num_d = NW'(pxx_q) + NW'(pyy_q);
  assign den_d = NW'(dxx_q) + NW'(dyy_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d; den_q <= den_d; dg3_q <= dg2_q;
      dx3_q <= dx2_q; dy3_q <= dy2_q; qx3_q <= qx2_q; qy3_q <= qy2_q;
    end
  end

  // Clamp codes ride with the divider payload
  logic lo_clamp, hi_clamp;
  assign lo_clamp = dg3_q || (num_q <= 0);
  assign hi_clamp = !lo_clamp && (num_q >= den_q);

  localparam int PW = 4 * DW + 3;
  logic [PW-1:0] dpay_i, dpay_o;
  logic          dv_o;
  logic [FRAC_BITS-1:0] quo;
  assign dpay_i = {dg3_q, lo_clamp, hi_clamp, dx3_q, dy3_q, qx3_q, qy3_q};

  psd_div #(.NW(NW), .PW(PW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q),
    .num_i((lo_clamp || hi_clamp) ? NW'(0) : num_q),
    .den_i((lo_clamp || hi_clamp) ? NW'(1) : den_q),
    .pay_i(dpay_i), .valid_o(dv_o), .quo_o(quo), .pay_o(dpay_o)
  );

  logic dg4, lo4, hi4;
  logic signed [DW-1:0] dx4, dy4, qx4, qy4;
  assign {dg4, lo4, hi4, dx4, dy4, qx4, qy4} = dpay_o;

  // Stage 4: t times d
  logic signed [FRAC_BITS+1:0] t_s;
  assign t_s = hi4 ? (FRAC_BITS+2)'(1 << FRAC_BITS)
             : (lo4 ? '0 : {2'b00, quo});
  logic v5_q, dg5_q;
  logic signed [RXW-1:0] tdx_q, tdy_q, qsx_q, qsy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= dv_o;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tdx_q <= RXW'(t_s * dx4);
      tdy_q <= RXW'(t_s * dy4);
      qsx_q <= RXW'(qx4) <<< FRAC_BITS;
      qsy_q <= RXW'(qy4) <<< FRAC_BITS;
      dg5_q <= dg4;
    end
  end

  // Stage 5: residual magnitudes
  logic v6_q, dg6_q;
  logic [RXW-1:0] mx_q, my_q;
  logic signed [RXW-1:0] rx, ry;
  assign rx = qsx_q - tdx_q;
  assign ry = qsy_q - tdy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= rx[RXW-1] ? RXW'(-rx) : rx;
      my_q <= ry[RXW-1] ? RXW'(-ry) : ry;
      dg6_q <= dg5_q;
    end
  end

  // Stage 6: squares
  logic v7_q, dg7_q;
  logic [2*RXW-1:0] sxx_q, syy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sxx_q <= mx_q * mx_q;
      syy_q <= my_q * my_q;
      dg7_q <= dg6_q;
    end
  end

  // Stage 7: sum
  logic v8_q, dg8_q;
  logic [SQW-1:0] sq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q  <= SQW'(sxx_q) + SQW'(syy_q);
      dg8_q <= dg7_q;
    end
  end

  logic sv_o, sdg_o;
  logic [RTW-1:0] root;
  psd_sqrt #(.SW(SQW), .PW(1)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q), .sq_i(sq_q),
    .pay_i(dg8_q), .valid_o(sv_o), .root_o(root), .pay_o(sdg_o)
  );

  // Output register
  logic vo_q;
  logic [DIST_BITS-1:0] dist_q;
  logic deg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= sv_o;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= DIST_BITS'(root);
      deg_q  <= sdg_o;
    end
  end

  assign valid_o      = vo_q;
  assign distance_o   = dist_q;
  assign degenerate_o = deg_q;

endmodule

>>> src/psd_div.sv
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS stages.
// Expects 0 < num < den. Carries residual payload alongside.
module psd_div
  import psd_pkg::*;
#(
  parameter int NW = 34,
  parameter int PW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NW-1:0]        num_i,
  input  logic [NW-1:0]        den_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic [FRAC_BITS-1:0] quo_o,
  output logic [PW-1:0]        pay_o
);

  logic [FRAC_BITS:0]      v_q;
  logic [NW:0]             r_q [FRAC_BITS+1];
  logic [NW-1:0]           d_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]    q_q [FRAC_BITS+1];
  logic [PW-1:0]           p_q [FRAC_BITS+1];

  always_comb begin
    v_q[0] = valid_i;
    r_q[0] = {1'b0, num_i};
    d_q[0] = den_i;
    q_q[0] = '0;
    p_q[0] = pay_i;
  end

  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
    logic [NW+1:0] sh;
    logic          ge;
    assign sh = {r_q[s], 1'b0};
    assign ge = sh >= {2'b00, d_q[s]};

    // Advance one quotient bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1] <= ge ? (NW+1)'(sh - {2'b00, d_q[s]}) : sh[NW:0];
        d_q[s+1] <= d_q[s];
        q_q[s+1] <= {q_q[s][FRAC_BITS-2:0], ge};
        p_q[s+1] <= p_q[s];
      end
    end
  end

  assign valid_o = v_q[FRAC_BITS];
  assign quo_o   = q_q[FRAC_BITS];
  assign pay_o   = p_q[FRAC_BITS];

endmodule

>>> src/psd_sqrt.sv
// Pipelined integer square root: one result bit per stage, RW stages.
// Remainder form: no multiplier, one add and compare per stage.
module psd_sqrt
  import psd_pkg::*;
#(
  parameter int SW = 72,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] sq_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [SW/2-1:0] root_o,
  output logic [PW-1:0] pay_o
);

  localparam int RW = SW / 2;

  logic [RW:0]   v_q;
  logic [SW-1:0] x_q [RW+1];
  logic [RW+1:0] rem_q [RW+1];
  logic [RW-1:0] rt_q [RW+1];
  logic [PW-1:0] p_q [RW+1];

  always_comb begin
    v_q[0]   = valid_i;
    x_q[0]   = sq_i;
    rem_q[0] = '0;
    rt_q[0]  = '0;
    p_q[0]   = pay_i;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+3:0] tr;
    logic [RW+3:0] tc;
    logic          ok;
    assign tr = {rem_q[s], x_q[s][SW-1:SW-2]};
    assign tc = {2'b00, rt_q[s], 2'b01};
    assign ok = tr >= tc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    // Take two radicand bits, decide one root bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ok ? (RW+2)'(tr - tc) : tr[RW+1:0];
        x_q[s+1]   <= {x_q[s][SW-3:0], 2'b00};
        rt_q[s+1]  <= {rt_q[s][RW-2:0], ok};
        p_q[s+1]   <= p_q[s];
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = rt_q[RW];
  assign pay_o   = p_q[RW];

endmodule

>>> src/psd_checker.sv
module psd_props
  import psd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 ready_o,
  input logic                 valid_o,
  input logic                 ready_i,
  input logic [DIST_BITS-1:0] distance_o,
  input logic                 degenerate_o
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(distance_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  // Input side is ready whenever output is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_o || ready_i) |-> ready_o)
    else $error("ready dropped with free output");

  // Stall only when the output is blocked
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> valid_o && !ready_i)
    else $error("spurious stall");

  // Nothing emerges right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("result after reset");

endmodule

bind point_segment_distance_core psd_props u_psd_props (
  .clk_i, .rst_ni, .ready_o, .valid_o, .ready_i, .distance_o, .degenerate_o
);
